>>> hdl/bfra_pkg.sv
// Shared types, constants and codes for the best-fit region allocator.
package bfra_pkg;

  localparam int MaxAreasDefault   = 32;
  localparam int OffsetBitsDefault = 21;
  localparam int CapResetValue     = 65536;
  localparam int QueueDepth        = 2;

  // Command codes.
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NO_MATCH = 2'd3;

  // Register indexes.
  localparam int REG_CAPACITY = 0;

endpackage

>>> hdl/best_fit_region_allocator.sv
// Top level of the best-fit region allocator.
// Usage:
// Input transactions (in_valid/in_ready) carry an allocate or a release.
// Each produces exactly one result transaction on out_valid/out_ready with
// a status and the granted or released area.
// A two-entry queue decouples intake from the table engine, so new
// transactions are taken while a result waits for the receiver.
// The engine walks the area table through one RAM read port. An allocate
// scans the table, then shifts entries up; a release walks it once and
// compacts it. An allocate runs with at most 33 entries, and the single
// table port sets the pace of every transaction.
// An allocate on a full table answers without a scan.
// After reset the table holds the two sentinels and capacity is 65536.
// A capacity write through the cfg port resets the table to the sentinels;
// write capacity only while the block is idle.
// When the receiver stalls the result holds and the queue fills, then
// in_ready drops.
module best_fit_region_allocator import bfra_pkg::*; #(
  parameter int MaxAreas   = MaxAreasDefault,
  parameter int OffsetBits = OffsetBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd,
  input  logic [OffsetBits-1:0] in_request_size,
  input  logic [OffsetBits-1:0] in_release_begin,
  input  logic [OffsetBits-1:0] in_release_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [OffsetBits-1:0] out_area_begin,
  output logic [OffsetBits-1:0] out_area_end,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic                  q_valid, q_pop, q_cmd;
  logic [OffsetBits-1:0] q_a, q_b;
  logic [OffsetBits-1:0] cap_r;
  logic                  cap_write;

  assign pready    = 1'b1;
  assign cap_write = psel && penable && pwrite && (paddr == 2'(REG_CAPACITY * 4));
  assign prdata    = (paddr == 2'(REG_CAPACITY * 4)) ? 32'(cap_r) : '0;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= OffsetBits'(CapResetValue);
    end else if (cap_write) begin
      cap_r <= pwdata[OffsetBits-1:0];
    end
  end

  bfra_front #(.OffsetBits(OffsetBits)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_request_size,
    .in_release_begin, .in_release_end,
    .q_valid, .q_pop, .q_cmd, .q_a, .q_b
  );

  bfra_back #(.MaxAreas(MaxAreas), .OffsetBits(OffsetBits)) u_back (
    .clk, .rst_n, .capacity(cap_r), .cap_write,
    .q_valid, .q_pop, .q_cmd, .q_a, .q_b,
    .out_valid, .out_ready, .out_status, .out_area_begin, .out_area_end
  );

endmodule

>>> hdl/bfra_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bfra_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/bfra_front.sv
// Front end: accepts input transactions and queues classified commands.
module bfra_front import bfra_pkg::*; #(
  parameter int OffsetBits = OffsetBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd,
  input  logic [OffsetBits-1:0] in_request_size,
  input  logic [OffsetBits-1:0] in_release_begin,
  input  logic [OffsetBits-1:0] in_release_end,
  output logic                  q_valid,
  input  logic                  q_pop,
  output logic                  q_cmd,
  output logic [OffsetBits-1:0] q_a,
  output logic [OffsetBits-1:0] q_b
);

  localparam int PtrBits = $clog2(QueueDepth);

  logic                  cmd_r [QueueDepth];
  logic [OffsetBits-1:0] a_r   [QueueDepth];
  logic [OffsetBits-1:0] b_r   [QueueDepth];
  logic [PtrBits-1:0]    wptr_r, rptr_r;
  logic [PtrBits:0]      cnt_r;
  logic                  push;

  assign in_ready = (cnt_r < (PtrBits+1)'(QueueDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_cmd    = cmd_r[rptr_r];
  assign q_a      = a_r[rptr_r];
  assign q_b      = b_r[rptr_r];

  // Queue storage: allocate keeps its size, release keeps its bounds.
  always_ff @(posedge clk) begin
    if (push) begin
      cmd_r[wptr_r] <= in_cmd;
      a_r[wptr_r]   <= (in_cmd == CMD_ALLOC) ? in_request_size : in_release_begin;
      b_r[wptr_r]   <= in_release_end;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (q_pop) rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_r + (PtrBits+1)'(push) - (PtrBits+1)'(q_pop);
    end
  end

endmodule

>>> hdl/bfra_back.sv
// Back end: scans the area table, inserts or compacts entries, forms results.
module bfra_back import bfra_pkg::*; #(
  parameter int MaxAreas   = MaxAreasDefault,
  parameter int OffsetBits = OffsetBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [OffsetBits-1:0] capacity,
  input  logic                  cap_write,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  logic                  q_cmd,
  input  logic [OffsetBits-1:0] q_a,
  input  logic [OffsetBits-1:0] q_b,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [OffsetBits-1:0] out_area_begin,
  output logic [OffsetBits-1:0] out_area_end
);

  localparam int Depth = MaxAreas + 2;
  localparam int IB    = $clog2(Depth + 1);
  localparam int AB    = $clog2(Depth);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_PICK = 7'b0000100,
    S_MOVE = 7'b0001000,
    S_REL  = 7'b0010000,
    S_DONE = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [IB-1:0]         cnt_r;
  logic [IB-1:0]         rd_r, wr_r;
  logic [IB-1:0]         pick_r;
  logic                  found_r, hit_r, rvalid_r;
  logic [IB-1:0]         ridx_r;
  logic [OffsetBits-1:0] best_r, prev_end_r, size_r, rb_r, re_r;
  logic [OffsetBits-1:0] nb_r, ne_r;
  logic                  cmd_r;
  logic                  ins_pend_r;

  logic                  we;
  logic [AB-1:0]         waddr, raddr;
  logic [2*OffsetBits-1:0] wdata, rdata, rent;
  logic [OffsetBits-1:0] rbeg, rend, gap;

  bfra_ram #(.Width(2*OffsetBits), .Depth(Depth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // The two sentinels are implied by position: the first entry is always
  // empty at zero and the last one always sits at the capacity.
  assign rent  = (ridx_r == '0) ? '0 :
                 (ridx_r == cnt_r - 1'b1) ? {capacity, capacity} : rdata;
  assign rbeg  = rent[2*OffsetBits-1:OffsetBits];
  assign rend  = rent[OffsetBits-1:0];
  assign gap   = rbeg - prev_end_r;
  assign q_pop = (state_r == S_IDLE) && q_valid && !cap_write;
  assign out_valid = (state_r == S_OUT);

  // Sequencer: reads one entry per cycle; writes happen one entry per cycle.
  always_comb begin
    state_nxt = state_r;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = rd_r[AB-1:0];
    case (state_r)
      S_IDLE: if (q_pop) begin
        if (q_cmd == CMD_ALLOC && cnt_r >= IB'(Depth)) state_nxt = S_DONE;
        else if (q_cmd == CMD_ALLOC) state_nxt = S_SCAN;
        else state_nxt = S_REL;
      end
      S_SCAN: if (rvalid_r && ridx_r == cnt_r - 1'b1) state_nxt = S_PICK;
      S_PICK: state_nxt = found_r ? S_MOVE : S_DONE;
      S_MOVE: begin
        // Shift entries up from the top down, then place the new entry.
        if (rvalid_r) begin
          we    = 1'b1;
          waddr = AB'(ridx_r + 1'b1);
          wdata = rent;
        end
        if (!ins_pend_r && rvalid_r && ridx_r == pick_r + 1'b1) begin
          state_nxt = S_MOVE;
        end
        if (ins_pend_r) begin
          we    = 1'b1;
          waddr = AB'(pick_r + 1'b1);
          wdata = {nb_r, ne_r};
          state_nxt = S_DONE;
        end
      end
      S_REL: begin
        if (rvalid_r && ridx_r != '0) begin
          if (ridx_r == cnt_r - 1'b1 ||
              !(rbeg == rb_r && rend == re_r)) begin
            we    = 1'b1;
            waddr = AB'(wr_r);
            wdata = rent;
          end
        end
        if (rvalid_r && ridx_r == cnt_r - 1'b1) state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_OUT;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= IB'(2);
      rvalid_r <= 1'b0;
      ins_pend_r <= 1'b0;
    end else if (cap_write) begin
      state_r  <= S_IDLE;
      cnt_r    <= IB'(2);
      rvalid_r <= 1'b0;
      ins_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          rvalid_r <= 1'b0;
          if (q_pop) begin
            cmd_r   <= q_cmd;
            size_r  <= q_a;
            rb_r    <= q_a;
            re_r    <= q_b;
            found_r <= 1'b0;
            hit_r   <= 1'b0;
            best_r  <= capacity;
            rd_r    <= '0;
            wr_r    <= IB'(1);
            out_status <= ST_FULL;
          end
        end
        S_SCAN: begin
          // Stream entries; each new begin closes the gap after the previous end.
          if (rd_r < cnt_r) begin
            rd_r <= rd_r + 1'b1;
          end
          rvalid_r <= (rd_r < cnt_r);
          ridx_r   <= rd_r;
          if (rvalid_r) begin
            prev_end_r <= rend;
            if (ridx_r != '0 && gap >= size_r && gap <= best_r) begin
              best_r  <= gap;
              pick_r  <= ridx_r - 1'b1;
              found_r <= 1'b1;
              nb_r    <= prev_end_r;
              ne_r    <= prev_end_r + size_r;
            end
          end
        end
        S_PICK: begin
          rvalid_r <= 1'b0;
          rd_r     <= cnt_r - 1'b1;
          if (!found_r) out_status <= ST_NO_FIT;
        end
        S_MOVE: begin
          if (ins_pend_r) begin
            ins_pend_r <= 1'b0;
            cnt_r      <= cnt_r + 1'b1;
            out_status <= ST_OK;
            rvalid_r   <= 1'b0;
          end else if (rvalid_r && ridx_r == pick_r + 1'b1) begin
            ins_pend_r <= 1'b1;
            rvalid_r   <= 1'b0;
          end else begin
            rvalid_r <= 1'b1;
            ridx_r   <= rd_r;
            rd_r     <= rd_r - 1'b1;
          end
        end
        S_REL: begin
          if (rd_r < cnt_r) rd_r <= rd_r + 1'b1;
          rvalid_r <= (rd_r < cnt_r);
          ridx_r   <= rd_r;
          if (rvalid_r && ridx_r != '0) begin
            if (ridx_r == cnt_r - 1'b1) begin
              cnt_r <= wr_r + 1'b1;
            end else if (rbeg == rb_r && rend == re_r) begin
              hit_r <= 1'b1;
            end else begin
              wr_r <= wr_r + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (cmd_r == CMD_RELEASE) begin
            out_status <= hit_r ? ST_OK : ST_NO_MATCH;
          end
        end
        default: ;
      endcase
    end
  end

  // Result payload, zero unless ok.
  always_comb begin
    out_area_begin = '0;
    out_area_end   = '0;
    if (out_status == ST_OK) begin
      out_area_begin = (cmd_r == CMD_ALLOC) ? nb_r : rb_r;
      out_area_end   = (cmd_r == CMD_ALLOC) ? ne_r : re_r;
    end
  end

endmodule

>>> hdl/bfra_checker.sv
// Port-level checker for the allocator, bound to the top level.
module bfra_checker import bfra_pkg::*; #(
  parameter int OffsetBits = OffsetBitsDefault
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [1:0]            out_status,
  input logic [OffsetBits-1:0] out_area_begin,
  input logic [OffsetBits-1:0] out_area_end,
  input logic                  pready
);

  // A failed result carries no area.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_area_begin == '0 && out_area_end == '0)
    else $error("nonzero area on failure");

  // An ok result never has its end before its begin.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |-> out_area_end >= out_area_begin)
    else $error("area end before begin");

  // Stalled results hold.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped while stalled");

  // The port is always ready.
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind best_fit_region_allocator bfra_checker #(.OffsetBits(OffsetBits)) u_chk (
  .clk, .rst_n, .out_valid, .out_ready, .out_status,
  .out_area_begin, .out_area_end, .pready
);

>>> tb/sv/testbench.sv
// Self-checking testbench for the best-fit region allocator.
module testbench import bfra_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth     = MaxAreasDefault + 2;
  localparam int HoldCyc   = 400;
  localparam int DogLimit  = 3000;
  localparam int DrainCyc  = 100;

  typedef struct packed {
    logic        cmd;
    logic [20:0] size;
    logic [20:0] rel_lo;
    logic [20:0] rel_hi;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [20:0] lo;
    logic [20:0] hi;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_cmd = 1'b0;
  logic [20:0] in_request_size = '0;
  logic [20:0] in_release_begin = '0;
  logic [20:0] in_release_end = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [20:0] out_area_begin;
  logic [20:0] out_area_end;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  best_fit_region_allocator dut (.*);

  // Two copies of the area table: index 0 follows the generator, index 1 the checker.
  logic [20:0] area_lo [2][Depth];
  logic [20:0] area_hi [2][Depth];
  int          area_cnt [2];
  int          capacity;

  request_t    pending_q [$];
  grant_t      grant_q [$];
  int          fails = 0;
  int          n_in = 0;
  int          n_out = 0;
  int          n_ok = 0;
  int          n_full = 0;
  int          n_nofit = 0;
  int          n_nomatch = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Reset one table copy to the two sentinels.
  function automatic void clear_areas(int s);
    for (int i = 0; i < Depth; i++) begin
      area_lo[s][i] = '0;
      area_hi[s][i] = '0;
    end
    area_lo[s][1] = 21'(capacity);
    area_hi[s][1] = 21'(capacity);
    area_cnt[s] = 2;
  endfunction

  // Best-fit allocate or release on one table copy; returns the result transaction.
  function automatic grant_t serve_request(int s, request_t rq);
    grant_t g;
    int best;
    int pick;
    int gap;
    int w;
    int last;
    logic hit;
    g = '0;
    if (rq.cmd == CMD_ALLOC) begin
      if (area_cnt[s] >= Depth) begin
        g.status = ST_FULL;
        return g;
      end
      best = capacity;
      pick = -1;
      for (int i = 0; i + 1 < area_cnt[s]; i++) begin
        gap = int'(area_lo[s][i+1]) - int'(area_hi[s][i]);
        if (gap >= int'(rq.size) && gap <= best) begin
          best = gap;
          pick = i;
        end
      end
      if (pick < 0) begin
        g.status = ST_NO_FIT;
        return g;
      end
      g.status = ST_OK;
      g.lo = area_hi[s][pick];
      g.hi = area_hi[s][pick] + rq.size;
      for (int i = area_cnt[s]; i > pick + 1; i--) begin
        area_lo[s][i] = area_lo[s][i-1];
        area_hi[s][i] = area_hi[s][i-1];
      end
      area_lo[s][pick+1] = g.lo;
      area_hi[s][pick+1] = g.hi;
      area_cnt[s]++;
    end else begin
      last = area_cnt[s] - 1;
      w = 1;
      hit = 1'b0;
      for (int r = 1; r < last; r++) begin
        if (area_lo[s][r] == rq.rel_lo && area_hi[s][r] == rq.rel_hi) begin
          hit = 1'b1;
        end else begin
          area_lo[s][w] = area_lo[s][r];
          area_hi[s][w] = area_hi[s][r];
          w++;
        end
      end
      area_lo[s][w] = area_lo[s][last];
      area_hi[s][w] = area_hi[s][last];
      area_cnt[s] = w + 1;
      for (int r = area_cnt[s]; r < Depth; r++) begin
        area_lo[s][r] = '0;
        area_hi[s][r] = '0;
      end
      if (hit) begin
        g.status = ST_OK;
        g.lo = rq.rel_lo;
        g.hi = rq.rel_hi;
      end else begin
        g.status = ST_NO_MATCH;
      end
    end
    return g;
  endfunction

  // Queue a request and advance the generator's copy of the table.
  task automatic queue_request(logic cmd, logic [20:0] sz, logic [20:0] lo, logic [20:0] hi);
    request_t rq;
    rq = '{cmd: cmd, size: sz, rel_lo: lo, rel_hi: hi};
    void'(serve_request(0, rq));
    pending_q.insert(pending_q.size(), rq);
  endtask

  // Random request, mostly allocates of modest size and releases of held areas.
  task automatic queue_random;
    int r;
    int k;
    logic [20:0] sz;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 99);
    if (r < 55) begin
      if (k < 15) sz = 21'($urandom_range(0, 3));
      else if (k < 70) sz = 21'($urandom_range(0, capacity / 16 + 1));
      else if (k < 92) sz = 21'($urandom_range(0, capacity));
      else sz = 21'($urandom);
      queue_request(CMD_ALLOC, sz, 21'($urandom), 21'($urandom));
    end else if (r < 85 && area_cnt[0] > 2) begin
      k = $urandom_range(1, area_cnt[0] - 2);
      queue_request(CMD_RELEASE, 21'($urandom), area_lo[0][k], area_hi[0][k]);
    end else if (r < 92 && area_cnt[0] > 2) begin
      // A near miss: right begin, end off by one.
      k = $urandom_range(1, area_cnt[0] - 2);
      queue_request(CMD_RELEASE, 21'($urandom), area_lo[0][k], area_hi[0][k] + 21'd1);
    end else begin
      queue_request(CMD_RELEASE, 21'($urandom), 21'($urandom), 21'($urandom));
    end
  endtask

  // Wait until every queued transaction has been answered.
  task automatic wait_drained;
    while (pending_q.size() != 0 || in_valid || grant_q.size() != 0) @(posedge clk);
    repeat (DrainCyc) @(posedge clk);
  endtask

  // Capacity register write over the APB port; the table returns to its sentinels.
  task automatic write_capacity(int cap);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 2'(REG_CAPACITY * 4);
    pwdata <= 32'(cap);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    capacity = cap;
    clear_areas(0);
    clear_areas(1);
  endtask

  // Stimulus: directed items, then random phases at several capacities.
  initial begin
    int caps [5];
    int counts [5];
    caps = '{CapResetValue, 1048576, 1, 4096, 65536};
    counts = '{190, 220, 100, 240, 190};
    capacity = CapResetValue;
    clear_areas(0);
    clear_areas(1);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    queue_request(CMD_ALLOC, 21'd0, '0, '0);
    queue_request(CMD_ALLOC, 21'd1, '0, '0);
    queue_request(CMD_RELEASE, '0, 21'd0, 21'd0);
    queue_request(CMD_RELEASE, '0, 21'd65536, 21'd65536);
    queue_request(CMD_ALLOC, 21'd100, '0, '0);
    queue_request(CMD_ALLOC, 21'd100, '0, '0);
    queue_request(CMD_RELEASE, '0, 21'd5, 21'd9);
    queue_request(CMD_ALLOC, 21'd65536, '0, '0);
    queue_request(CMD_ALLOC, 21'd1048576, '0, '0);
    queue_request(CMD_ALLOC, 21'h1FFFFF, '0, '0);
    queue_request(CMD_RELEASE, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF);
    queue_request(CMD_ALLOC, 21'd65000, '0, '0);
    queue_request(CMD_ALLOC, 21'd400, '0, '0);

    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        wait_drained();
        write_capacity(caps[p]);
      end
      for (int n = 0; n < counts[p]; n++) queue_random();
    end
    wait_drained();

    $display("Sent %0d requests over five capacities; %0d ok, %0d no-fit, %0d full, %0d unmatched.",
             n_in, n_ok, n_nofit, n_full, n_nomatch);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Driver: offers queued requests with random gaps, except in a stretch where it offers without gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        grant_q.insert(grant_q.size(), serve_request(1, '{cmd: in_cmd, size: in_request_size,
                                                     rel_lo: in_release_begin,
                                                     rel_hi: in_release_end}));
        n_in++;
      end
      if (pending_q.size() != 0 &&
          ((n_in > 400 && n_in < 550) || $urandom_range(0, 99) >= 28)) begin
        in_valid <= 1'b1;
        in_cmd <= pending_q[0].cmd;
        in_request_size <= pending_q[0].size;
        in_release_begin <= pending_q[0].rel_lo;
        in_release_end <= pending_q[0].rel_hi;
        void'(pending_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transaction, and stalls the receiver at random.
  int hold_left = 0;
  logic hold_done = 1'b0;
  always @(posedge clk) begin
    grant_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_out++;
        if (grant_q.size() == 0) begin
          $error("Result with no request outstanding: status %0d", out_status);
          fails++;
        end else begin
          want = grant_q.pop_front();
          if (out_status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fails++;
          end
          if (out_area_begin != want.lo) begin
            $error("area_begin: expected %0d, got %0d", want.lo, out_area_begin);
            fails++;
          end
          if (out_area_end != want.hi) begin
            $error("area_end: expected %0d, got %0d", want.hi, out_area_end);
            fails++;
          end
          case (want.status)
            ST_OK:     n_ok++;
            ST_NO_FIT: n_nofit++;
            ST_FULL:   n_full++;
            default:   n_nomatch++;
          endcase
        end
      end
      // One long hold-off lets the internal queue fill and stall intake.
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && n_out == 60) begin
        hold_done <= 1'b1;
        hold_left <= HoldCyc;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (n_out > 400 && n_out < 550) || $urandom_range(0, 99) >= 28;
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  int idle_cyc = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= DogLimit) begin
      $display("Watchdog expired with %0d results outstanding.", grant_q.size());
      $display("tb: failure");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

endmodule
